### design/nattab_pkg.sv
// nattab_pkg: shared types and codes for the nat table with aging
// used by nat_table_with_aging_unit; no dependencies
`timescale 1ns / 1ps

package nattab_pkg;

    // operation selector carried in the input tuser
    typedef enum logic [1:0] {
        FUNC_LOOKUP = 2'd0,
        FUNC_INSERT = 2'd1,
        FUNC_TICK   = 2'd2,
        FUNC_CLEAR  = 2'd3
    } t_func;

    // result status codes
    localparam int STATUS_W = 3;
    typedef logic [STATUS_W-1:0] t_status;
    localparam t_status STATUS_DONE     = 3'd0;
    localparam t_status STATUS_NEW      = 3'd1;
    localparam t_status STATUS_REFRESH  = 3'd2;
    localparam t_status STATUS_MISMATCH = 3'd3;
    localparam t_status STATUS_FULL     = 3'd4;

    // field widths
    localparam int KEY_W  = 16;
    localparam int ADDR_W = 32;
    localparam int AGE_W  = 8;

    // packed entry word in the data memory: key, inner, outer from the lowest bit
    localparam int ENTRY_W = KEY_W + 2 * ADDR_W;

    localparam logic [AGE_W-1:0] TIMEOUT_RESET = 8'd30;

    // sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FIN,
        ST_DONE
    } t_state;

endpackage

### design/nattab_ram.sv
// nattab_ram: generic simple dual port ram, one write and one registered read port
// no dependencies
`timescale 1ns / 1ps

module nattab_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                     i_wdata,
    input  logic                                 i_re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                     o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### design/nat_table_with_aging_unit.sv
// nat_table_with_aging_unit: nat translation table with aging timeout, top level
// depends on nattab_pkg and nattab_ram
`timescale 1ns / 1ps

// Usage
// - s_axis carries one command word: tuser is the operation (lookup, insert,
//   tick, clear), tdata the key and the internal and external addresses
// - m_axis returns one result word per command: hit flag, both addresses
//   of the hit entry and a status code
// - i_cfg_valid/i_cfg_data write the timeout in ticks; always ready, write
//   it only while no command is in flight
// - lookup, insert and tick scan every slot through the entry and age
//   memories, one read per cycle, before the finish and done states;
//   clear skips the scan and goes straight to finish
// - the next command is accepted in the cycle after the result is loaded
//   into the output register, so a new command is not taken while one is
//   in flight; the scan through the single read port sets its length
// - a stalled receiver holds the result in the output register; a finished
//   command waits in its last state until the register is free
// - synchronous active-low reset empties the table through per-slot valid
//   flops and loads the timeout with 30; no clearing pass is needed
module nat_table_with_aging_unit #(
    parameter int TABLE_ENTRIES = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // command stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [79:0] s_axis_tdata,   // key_id[15:0], inner_addr[47:16], outer_addr[79:48]
    input  logic [1:0]  s_axis_tuser,   // func[1:0]
    // result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [71:0] m_axis_tdata,   // found[0], found_inner_addr[32:1],
                                        // found_outer_addr[64:33], status[67:65], zero
    // timeout register write
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_data
);

    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);
    localparam int KW = nattab_pkg::KEY_W;
    localparam int AW = nattab_pkg::ADDR_W;
    localparam int GW = nattab_pkg::AGE_W;

    nattab_pkg::t_state r_state, n_state;

    // latched command
    nattab_pkg::t_func  r_func;
    logic [KW-1:0]      r_key;
    logic [AW-1:0]      r_in_ip;
    logic [AW-1:0]      r_ex_ip;

    logic [GW-1:0]      r_timeout;
    logic [TABLE_ENTRIES-1:0] r_valid;

    // scan pipeline
    logic               r_rd_active;
    logic [IDX_W-1:0]   r_rd_idx;
    logic               r_chk_vld;
    logic [IDX_W-1:0]   r_chk_idx;

    // scan results
    logic               r_hit;
    logic [IDX_W-1:0]   r_hit_idx;
    logic [AW-1:0]      r_hit_in;
    logic [AW-1:0]      r_hit_ex;
    logic               r_mism;
    logic               r_free_ok;
    logic [IDX_W-1:0]   r_free_idx;

    // finished result and output register
    logic               r_res_found;
    logic [AW-1:0]      r_res_in;
    logic [AW-1:0]      r_res_ex;
    nattab_pkg::t_status r_res_status;
    logic               r_out_vld;
    logic               r_out_found;
    logic [AW-1:0]      r_out_in;
    logic [AW-1:0]      r_out_ex;
    nattab_pkg::t_status r_out_status;

    // memory ports
    logic [nattab_pkg::ENTRY_W-1:0] w_ent_rdata;
    logic [nattab_pkg::ENTRY_W-1:0] w_ent_wdata;
    logic               w_ent_we;
    logic [GW-1:0]      w_age_rdata;
    logic [GW-1:0]      w_age_wdata;
    logic               w_age_we;
    logic [IDX_W-1:0]   w_age_waddr;

    logic               w_in_acc;
    logic               w_out_free;
    logic [KW-1:0]      w_rd_key;
    logic [AW-1:0]      w_rd_in;
    logic [AW-1:0]      w_rd_ex;
    logic               w_slot_vld;
    logic [GW:0]        w_new_age;
    logic               w_expire;
    logic               w_ins_new;
    logic [IDX_W-1:0]   w_wr_idx;

    assign w_in_acc   = s_axis_tvalid && s_axis_tready;
    assign w_out_free = !r_out_vld || m_axis_tready;
    assign o_cfg_ready = 1'b1;

    // fields of the entry read back in the check stage
    assign w_rd_key   = w_ent_rdata[KW-1:0];
    assign w_rd_in    = w_ent_rdata[KW+AW-1:KW];
    assign w_rd_ex    = w_ent_rdata[KW+2*AW-1:KW+AW];
    assign w_slot_vld = r_valid[r_chk_idx];
    assign w_new_age  = {1'b0, w_age_rdata} + {{GW{1'b0}}, 1'b1};
    assign w_expire   = w_new_age > {1'b0, r_timeout};

    // insert of a new entry goes to the lowest free slot found in the scan
    assign w_ins_new  = (r_state == nattab_pkg::ST_FIN) && (r_func == nattab_pkg::FUNC_INSERT)
                        && !r_hit && r_free_ok;
    assign w_wr_idx   = r_hit ? r_hit_idx : r_free_idx;

    // memory write selection: tick ages in the check stage, insert writes at finish
    always_comb begin
        w_ent_we    = w_ins_new;
        w_ent_wdata = {r_ex_ip, r_in_ip, r_key};
        w_age_we    = 1'b0;
        w_age_waddr = r_chk_idx;
        w_age_wdata = w_new_age[GW-1:0];
        if (r_state == nattab_pkg::ST_SCAN) begin
            w_age_we = r_chk_vld && (r_func == nattab_pkg::FUNC_TICK) && w_slot_vld && !w_expire;
        end else if (r_state == nattab_pkg::ST_FIN) begin
            w_age_we    = (r_func == nattab_pkg::FUNC_INSERT) && (r_hit || r_free_ok);
            w_age_waddr = w_wr_idx;
            w_age_wdata = '0;
        end
    end

    nattab_ram #(
        .WIDTH (nattab_pkg::ENTRY_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_entry_ram (
        .i_clk   (i_clk),
        .i_we    (w_ent_we),
        .i_waddr (w_wr_idx),
        .i_wdata (w_ent_wdata),
        .i_re    (r_rd_active),
        .i_raddr (r_rd_idx),
        .o_rdata (w_ent_rdata)
    );

    nattab_ram #(
        .WIDTH (GW),
        .DEPTH (TABLE_ENTRIES)
    ) u_age_ram (
        .i_clk   (i_clk),
        .i_we    (w_age_we),
        .i_waddr (w_age_waddr),
        .i_wdata (w_age_wdata),
        .i_re    (r_rd_active),
        .i_raddr (r_rd_idx),
        .o_rdata (w_age_rdata)
    );

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= nattab_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and handshake
    always_comb begin
        n_state       = r_state;
        s_axis_tready = 1'b0;
        unique case (r_state)
            nattab_pkg::ST_IDLE: begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid) begin
                    if (nattab_pkg::t_func'(s_axis_tuser) == nattab_pkg::FUNC_CLEAR) begin
                        n_state = nattab_pkg::ST_FIN;
                    end else begin
                        n_state = nattab_pkg::ST_SCAN;
                    end
                end
            end
            nattab_pkg::ST_SCAN: begin
                if (r_chk_vld && r_chk_idx == LAST_IDX) begin
                    n_state = nattab_pkg::ST_FIN;
                end
            end
            nattab_pkg::ST_FIN: begin
                n_state = nattab_pkg::ST_DONE;
            end
            nattab_pkg::ST_DONE: begin
                if (w_out_free) begin
                    n_state = nattab_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = nattab_pkg::ST_IDLE;
            end
        endcase
    end

    // timeout register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout <= nattab_pkg::TIMEOUT_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_timeout <= i_cfg_data;
        end
    end

    // command latch
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_func  <= nattab_pkg::t_func'(s_axis_tuser);
            r_key   <= s_axis_tdata[KW-1:0];
            r_in_ip <= s_axis_tdata[KW+AW-1:KW];
            r_ex_ip <= s_axis_tdata[KW+2*AW-1:KW+AW];
        end
    end

    // read sequencer: one slot address per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_active <= 1'b0;
            r_rd_idx    <= '0;
            r_chk_vld   <= 1'b0;
            r_chk_idx   <= '0;
        end else begin
            r_chk_vld <= r_rd_active;
            r_chk_idx <= r_rd_idx;
            if (w_in_acc) begin
                r_rd_active <= nattab_pkg::t_func'(s_axis_tuser) != nattab_pkg::FUNC_CLEAR;
                r_rd_idx    <= '0;
            end else if (r_rd_active) begin
                if (r_rd_idx == LAST_IDX) begin
                    r_rd_active <= 1'b0;
                end else begin
                    r_rd_idx <= r_rd_idx + 1'b1;
                end
            end
        end
    end

    // check stage: key match, first free slot, aging
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_hit     <= 1'b0;
            r_mism    <= 1'b0;
            r_free_ok <= 1'b0;
        end else if (r_chk_vld) begin
            if (w_slot_vld && w_rd_key == r_key && !r_hit) begin
                r_hit     <= 1'b1;
                r_hit_idx <= r_chk_idx;
                r_hit_in  <= w_rd_in;
                r_hit_ex  <= w_rd_ex;
                r_mism    <= (w_rd_in != r_in_ip) || (w_rd_ex != r_ex_ip);
            end
            if (!w_slot_vld && !r_free_ok) begin
                r_free_ok  <= 1'b1;
                r_free_idx <= r_chk_idx;
            end
        end
    end

    // valid bits: tick expiry, new insert, clear
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (r_state == nattab_pkg::ST_SCAN) begin
            if (r_chk_vld && r_func == nattab_pkg::FUNC_TICK && w_slot_vld && w_expire) begin
                r_valid[r_chk_idx] <= 1'b0;
            end
        end else if (r_state == nattab_pkg::ST_FIN) begin
            if (r_func == nattab_pkg::FUNC_CLEAR) begin
                r_valid <= '0;
            end else if (w_ins_new) begin
                r_valid[r_free_idx] <= 1'b1;
            end
        end
    end

    // result forming at finish
    always_ff @(posedge i_clk) begin
        if (r_state == nattab_pkg::ST_FIN) begin
            r_res_found  <= 1'b0;
            r_res_in     <= '0;
            r_res_ex     <= '0;
            r_res_status <= nattab_pkg::STATUS_DONE;
            case (r_func)
                nattab_pkg::FUNC_LOOKUP: begin
                    if (r_hit) begin
                        r_res_found <= 1'b1;
                        r_res_in    <= r_hit_in;
                        r_res_ex    <= r_hit_ex;
                    end
                end
                nattab_pkg::FUNC_INSERT: begin
                    if (r_hit) begin
                        r_res_status <= r_mism ? nattab_pkg::STATUS_MISMATCH
                                               : nattab_pkg::STATUS_REFRESH;
                    end else if (r_free_ok) begin
                        r_res_status <= nattab_pkg::STATUS_NEW;
                    end else begin
                        r_res_status <= nattab_pkg::STATUS_FULL;
                    end
                end
                default: begin
                    r_res_status <= nattab_pkg::STATUS_DONE;
                end
            endcase
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (r_state == nattab_pkg::ST_DONE && w_out_free) begin
            r_out_vld <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == nattab_pkg::ST_DONE && w_out_free) begin
            r_out_found  <= r_res_found;
            r_out_in     <= r_res_in;
            r_out_ex     <= r_res_ex;
            r_out_status <= r_res_status;
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = {4'b0000, r_out_status, r_out_ex, r_out_in, r_out_found};

endmodule

### tb/sv/nat_table_with_aging_unit_tb.sv
// nat_table_with_aging_unit_tb: self-checking bench for the nat table with aging
// drives command words, predicts every result word and compares; needs nattab_pkg
`timescale 1ns / 1ps

module nat_table_with_aging_unit_tb;

    localparam int SLOTS    = 16;
    localparam int KEY_POOL = 24;

    // one result word, unpacked view
    typedef struct packed {
        logic                          found;
        logic [nattab_pkg::ADDR_W-1:0] inner;
        logic [nattab_pkg::ADDR_W-1:0] outer;
        nattab_pkg::t_status           status;
    } t_nat_result;

    // one row of the directed table
    typedef struct {
        nattab_pkg::t_func             func;
        logic [nattab_pkg::KEY_W-1:0]  key;
        logic [nattab_pkg::ADDR_W-1:0] inner;
        logic [nattab_pkg::ADDR_W-1:0] outer;
        bit                            typed;
        t_nat_result                   want;
    } t_dir_row;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [79:0] s_axis_tdata  = '0;
    logic [1:0]  s_axis_tuser  = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [71:0] m_axis_tdata;
    logic        i_cfg_valid   = 1'b0;
    logic        o_cfg_ready;
    logic [7:0]  i_cfg_data    = '0;

    // typed expectation that travels with the word on offer
    bit          cur_typed = 1'b0;
    t_nat_result cur_want  = '0;

    // predicted table contents
    bit                            tbl_valid [SLOTS];
    logic [nattab_pkg::KEY_W-1:0]  tbl_key   [SLOTS];
    logic [nattab_pkg::ADDR_W-1:0] tbl_inner [SLOTS];
    logic [nattab_pkg::ADDR_W-1:0] tbl_outer [SLOTS];
    logic [nattab_pkg::AGE_W-1:0]  tbl_age   [SLOTS];
    logic [nattab_pkg::AGE_W-1:0]  tbl_timeout = nattab_pkg::TIMEOUT_RESET;

    t_nat_result pending_results[$];
    int          n_errors = 0;

    // key pool so that hits, refreshes and a full table are common
    logic [nattab_pkg::KEY_W-1:0]  pool_key   [KEY_POOL];
    logic [nattab_pkg::ADDR_W-1:0] pool_inner [KEY_POOL];
    logic [nattab_pkg::ADDR_W-1:0] pool_outer [KEY_POOL];

    // idling controls
    bit tx_idle_en     = 1'b1;
    bit rx_idle_en     = 1'b1;
    bit quiet_end      = 1'b0;
    int rx_hold_cycles = 0;
    int rand_count     = 0;

    nat_table_with_aging_unit #(
        .TABLE_ENTRIES(SLOTS)
    ) u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    // clock
    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // run limit
    initial begin
        #5000000;
        $display("nat_table_with_aging_unit_tb: errors");
        $finish;
    end

    function automatic t_nat_result res_of(logic f, logic [nattab_pkg::ADDR_W-1:0] a,
                                           logic [nattab_pkg::ADDR_W-1:0] b,
                                           nattab_pkg::t_status st);
        t_nat_result r;
        r.found  = f;
        r.inner  = a;
        r.outer  = b;
        r.status = st;
        return r;
    endfunction

    // table behavior for one command word
    task automatic nat_predict(input nattab_pkg::t_func f,
                               input logic [nattab_pkg::KEY_W-1:0] k,
                               input logic [nattab_pkg::ADDR_W-1:0] a,
                               input logic [nattab_pkg::ADDR_W-1:0] b,
                               output t_nat_result r);
        int hit;
        int i;
        logic [nattab_pkg::AGE_W:0] nage;
        r   = res_of(1'b0, '0, '0, nattab_pkg::STATUS_DONE);
        hit = -1;
        for (i = 0; i < SLOTS; i++) begin
            if (hit < 0 && tbl_valid[i] && tbl_key[i] == k) hit = i;
        end
        case (f)
            nattab_pkg::FUNC_LOOKUP: begin
                if (hit >= 0) begin
                    r.found = 1'b1;
                    r.inner = tbl_inner[hit];
                    r.outer = tbl_outer[hit];
                end
            end
            nattab_pkg::FUNC_INSERT: begin
                if (hit >= 0) begin
                    // refresh keeps the stored addresses
                    tbl_age[hit] = '0;
                    r.status = (tbl_inner[hit] != a || tbl_outer[hit] != b) ?
                               nattab_pkg::STATUS_MISMATCH : nattab_pkg::STATUS_REFRESH;
                end else begin
                    // lowest free slot, or full
                    r.status = nattab_pkg::STATUS_FULL;
                    for (i = 0; i < SLOTS; i++) begin
                        if (!tbl_valid[i] && r.status == nattab_pkg::STATUS_FULL) begin
                            tbl_valid[i] = 1'b1;
                            tbl_key[i]   = k;
                            tbl_inner[i] = a;
                            tbl_outer[i] = b;
                            tbl_age[i]   = '0;
                            r.status     = nattab_pkg::STATUS_NEW;
                        end
                    end
                end
            end
            nattab_pkg::FUNC_TICK: begin
                // age one bit wider so that a timeout of 255 still expires
                for (i = 0; i < SLOTS; i++) begin
                    if (tbl_valid[i]) begin
                        nage = {1'b0, tbl_age[i]} + 1'b1;
                        if (nage > {1'b0, tbl_timeout}) tbl_valid[i] = 1'b0;
                        else tbl_age[i] = nage[nattab_pkg::AGE_W-1:0];
                    end
                end
            end
            default: begin
                for (i = 0; i < SLOTS; i++) tbl_valid[i] = 1'b0;
            end
        endcase
    endtask

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            n_errors++;
        end
    endtask

    // prediction on accepted command words, checking on accepted result words
    always @(posedge i_clk) begin
        t_nat_result pred;
        t_nat_result want;
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) tbl_timeout = i_cfg_data;
            if (s_axis_tvalid && s_axis_tready) begin
                nat_predict(nattab_pkg::t_func'(s_axis_tuser), s_axis_tdata[15:0],
                            s_axis_tdata[47:16], s_axis_tdata[79:48], pred);
                pending_results.push_back(cur_typed ? cur_want : pred);
            end
            if (m_axis_tvalid && m_axis_tready) begin
                if (pending_results.size() == 0) begin
                    $error("result word with no expectation: %0h", m_axis_tdata);
                    n_errors++;
                end else begin
                    want = pending_results.pop_front();
                    check_field("found", 32'(want.found), 32'(m_axis_tdata[0]));
                    check_field("found_inner_addr", want.inner, m_axis_tdata[32:1]);
                    check_field("found_outer_addr", want.outer, m_axis_tdata[64:33]);
                    check_field("status", 32'(want.status), 32'(m_axis_tdata[67:65]));
                end
            end
        end
    end

    // receiver: random stall bursts, a long hold on request, none at the end
    initial begin
        int stall_left;
        stall_left = 0;
        forever begin
            @(negedge i_clk);
            if (rx_hold_cycles > 0) begin
                m_axis_tready <= 1'b0;
                rx_hold_cycles--;
            end else if (quiet_end || !rx_idle_en) begin
                m_axis_tready <= 1'b1;
            end else if (stall_left > 0) begin
                m_axis_tready <= 1'b0;
                stall_left--;
            end else if ($urandom_range(0, 5) == 0) begin
                m_axis_tready <= 1'b0;
                stall_left = $urandom_range(1, 4) - 1;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // offer one command word, returns at the edge that accepts it
    task automatic send_cmd(nattab_pkg::t_func f, logic [nattab_pkg::KEY_W-1:0] k,
                            logic [nattab_pkg::ADDR_W-1:0] a,
                            logic [nattab_pkg::ADDR_W-1:0] b, bit typed, t_nat_result want);
        int gap;
        gap = (!quiet_end && tx_idle_en && $urandom_range(0, 4) == 0) ?
              $urandom_range(1, 4) : 0;
        @(negedge i_clk);
        repeat (gap) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {b, a, k};
        s_axis_tuser  <= f;
        cur_typed     <= typed;
        cur_want      <= want;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    // drop valid and wait until every expected word is back
    task automatic drain_results();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    // timeout write while the table is idle
    task automatic write_timeout(logic [7:0] v);
        drain_results();
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // random command word: mostly pool keys with their usual addresses
    task automatic send_random(int tick_pct);
        int r;
        int p;
        nattab_pkg::t_func f;
        logic [nattab_pkg::KEY_W-1:0] k;
        logic [nattab_pkg::ADDR_W-1:0] a;
        logic [nattab_pkg::ADDR_W-1:0] b;
        rand_count++;
        if (rand_count % 40 == 0) begin
            tx_idle_en = ($urandom_range(0, 3) != 0);
            rx_idle_en = ($urandom_range(0, 3) != 0);
        end
        r = $urandom_range(0, 99);
        if (r < 3) f = nattab_pkg::FUNC_CLEAR;
        else if (r < 3 + tick_pct) f = nattab_pkg::FUNC_TICK;
        else if (r < 3 + tick_pct + (97 - tick_pct) / 2) f = nattab_pkg::FUNC_LOOKUP;
        else f = nattab_pkg::FUNC_INSERT;
        if ($urandom_range(0, 99) < 85) begin
            p = $urandom_range(0, KEY_POOL - 1);
            k = pool_key[p];
            a = pool_inner[p];
            b = pool_outer[p];
            case ($urandom_range(0, 9))
                0: a = $urandom;
                1: b = $urandom;
                2: begin
                    a = $urandom;
                    b = $urandom;
                end
                default: ;
            endcase
        end else begin
            k = 16'($urandom);
            a = $urandom;
            b = $urandom;
        end
        send_cmd(f, k, a, b, 1'b0, '0);
    endtask

    // main sequence
    initial begin
        t_dir_row dir_rows[$];
        int tmo_list[6];
        int i;
        int ph;
        int n;
        int wait_cnt;
        logic [7:0] tmo;

        for (i = 0; i < SLOTS; i++) tbl_valid[i] = 1'b0;
        for (i = 0; i < KEY_POOL; i++) begin
            pool_key[i]   = 16'($urandom);
            pool_inner[i] = $urandom;
            pool_outer[i] = $urandom;
        end
        pool_key[0] = 16'h0000;
        pool_key[1] = 16'hFFFF;

        // directed table: extremes, every operation, refresh, mismatch, clear, full
        dir_rows.push_back('{nattab_pkg::FUNC_LOOKUP, 16'h0000, 32'h0, 32'h0, 1'b1,
                             res_of(1'b0, 32'h0, 32'h0, nattab_pkg::STATUS_DONE)});
        dir_rows.push_back('{nattab_pkg::FUNC_INSERT, 16'hFFFF, 32'hFFFF_FFFF,
                             32'hFFFF_FFFF, 1'b1,
                             res_of(1'b0, 32'h0, 32'h0, nattab_pkg::STATUS_NEW)});
        dir_rows.push_back('{nattab_pkg::FUNC_LOOKUP, 16'hFFFF, 32'h0, 32'h0, 1'b1,
                             res_of(1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                                    nattab_pkg::STATUS_DONE)});
        dir_rows.push_back('{nattab_pkg::FUNC_INSERT, 16'hFFFF, 32'hFFFF_FFFF,
                             32'hFFFF_FFFF, 1'b1,
                             res_of(1'b0, 32'h0, 32'h0, nattab_pkg::STATUS_REFRESH)});
        dir_rows.push_back('{nattab_pkg::FUNC_INSERT, 16'hFFFF, 32'h0, 32'h0, 1'b1,
                             res_of(1'b0, 32'h0, 32'h0, nattab_pkg::STATUS_MISMATCH)});
        dir_rows.push_back('{nattab_pkg::FUNC_TICK, 16'hFFFF, 32'hFFFF_FFFF,
                             32'hFFFF_FFFF, 1'b1,
                             res_of(1'b0, 32'h0, 32'h0, nattab_pkg::STATUS_DONE)});
        dir_rows.push_back('{nattab_pkg::FUNC_LOOKUP, 16'hFFFF, 32'h0, 32'h0, 1'b1,
                             res_of(1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                                    nattab_pkg::STATUS_DONE)});
        dir_rows.push_back('{nattab_pkg::FUNC_CLEAR, 16'h0000, 32'h0, 32'h0, 1'b1,
                             res_of(1'b0, 32'h0, 32'h0, nattab_pkg::STATUS_DONE)});
        dir_rows.push_back('{nattab_pkg::FUNC_LOOKUP, 16'hFFFF, 32'h0, 32'h0, 1'b1,
                             res_of(1'b0, 32'h0, 32'h0, nattab_pkg::STATUS_DONE)});
        for (i = 0; i < SLOTS; i++) begin
            dir_rows.push_back('{nattab_pkg::FUNC_INSERT, 16'(i * 16'h1111), $urandom,
                                 $urandom, 1'b1,
                                 res_of(1'b0, 32'h0, 32'h0, nattab_pkg::STATUS_NEW)});
        end
        dir_rows.push_back('{nattab_pkg::FUNC_INSERT, 16'h1234, 32'h0, 32'h0, 1'b1,
                             res_of(1'b0, 32'h0, 32'h0, nattab_pkg::STATUS_FULL)});

        // reset
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[j]) begin
            send_cmd(dir_rows[j].func, dir_rows[j].key, dir_rows[j].inner,
                     dir_rows[j].outer, dir_rows[j].typed, dir_rows[j].want);
        end

        // random part at the reset timeout, with a long receiver hold and a full drain
        for (i = 0; i < 250; i++) begin
            send_random(15);
            if (i == 100) rx_hold_cycles = 300;
            if (i == 150) drain_results();
        end

        // further timeout settings, extremes among them
        tmo_list = '{1, 255, 0, 4, -1, 2};
        for (ph = 0; ph < 6; ph++) begin
            tmo = (tmo_list[ph] < 0) ? 8'($urandom_range(5, 254)) : 8'(tmo_list[ph]);
            write_timeout(tmo);
            if (tmo == 8'd255) begin
                // fill, then age past the widest timeout
                for (i = 0; i < 40; i++) send_random(5);
                for (i = 0; i < 258; i++) send_cmd(nattab_pkg::FUNC_TICK, 16'($urandom),
                                                   $urandom, $urandom, 1'b0, '0);
                for (i = 0; i < 40; i++) send_random(5);
            end else begin
                n = 168;
                for (i = 0; i < n; i++) begin
                    if (ph == 5 && i >= n - 100) quiet_end = 1'b1;
                    send_random((tmo <= 8'd4) ? 6 : 15);
                end
            end
        end

        // wait for the tail, with a limit
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        wait_cnt = 0;
        while (pending_results.size() != 0 && wait_cnt < 100000) begin
            @(posedge i_clk);
            wait_cnt++;
        end
        repeat (40) @(posedge i_clk);
        if (pending_results.size() != 0) begin
            $error("%0d expected result words never arrived", pending_results.size());
            n_errors++;
        end

        if (n_errors == 0) begin
            $display("nat_table_with_aging_unit_tb: clean");
        end else begin
            $display("nat_table_with_aging_unit_tb: errors");
        end
        $finish;
    end

endmodule

### nat_table_with_aging_unit.f
design/nattab_pkg.sv
design/nattab_ram.sv
design/nat_table_with_aging_unit.sv
tb/sv/nat_table_with_aging_unit_tb.sv
